### design/seird_euler_step_top_macros.svh
// ----------------------------------------------------------------------------
// SEIRD Euler step assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SEIRD_EULER_STEP_TOP_MACROS_SVH
`define SEIRD_EULER_STEP_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEIRD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SEIRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/seird_pkg.sv
// ----------------------------------------------------------------------------
// SEIRD Euler step package
// Field widths, register indexes, ALU codes and the step micro-program.
// ----------------------------------------------------------------------------
package seird_pkg;

    localparam int FIELD_W          = 32;
    localparam int DEF_VALUE_WIDTH  = 32;
    localparam int DEF_FRAC_BITS    = 24;
    localparam int DIG_W            = 16;
    localparam int CFG_INDEX_W      = 4;
    localparam int PC_W             = 6;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALPHA = 4'd0,
        REG_BETA  = 4'd1,
        REG_GAMMA = 4'd2,
        REG_DELTA = 4'd3,
        REG_EPS   = 4'd4,
        REG_MU    = 4'd5,
        REG_NU    = 4'd6,
        REG_H     = 4'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_DIFF,
        OP_MUL,
        OP_UPD
    } alu_op_t;

    typedef enum logic [4:0] {
        SRC_S, SRC_E, SRC_I, SRC_R, SRC_D,
        SRC_N, SRC_INF, SRC_INC, SRC_CUR, SRC_DTH, SRC_WAN,
        SRC_PS, SRC_NS, SRC_NE, SRC_NI, SRC_NR,
        SRC_T, SRC_U, SRC_TOT,
        SRC_ALPHA, SRC_BETA, SRC_GAMMA, SRC_DELTA, SRC_EPS,
        SRC_MU, SRC_NU, SRC_H, SRC_ZERO
    } src_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        logic    neg;
    } alu_ctrl_t;

    typedef struct packed {
        logic done;
        logic clamp;
        logic neg;
    } alu_stat_t;

    typedef struct packed {
        alu_op_t op;
        src_t    a;
        src_t    b;
        src_t    dst;
        logic    last;
    } uop_t;

    // A load only needs the alive total, so it enters the program here.
    localparam logic [PC_W-1:0] ALIVE_START = 6'd35;

    function automatic uop_t mk(input alu_op_t op, input src_t a, input src_t b,
                                input src_t dst, input logic last);
        uop_t u;
        u.op   = op;
        u.a    = a;
        u.b    = b;
        u.dst  = dst;
        u.last = last;
        return u;
    endfunction

    function automatic uop_t prog_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = mk(OP_ADD,  SRC_S,     SRC_E,    SRC_N,   1'b0);
            6'd1:  u = mk(OP_ADD,  SRC_N,     SRC_I,    SRC_N,   1'b0);
            6'd2:  u = mk(OP_ADD,  SRC_N,     SRC_R,    SRC_N,   1'b0);
            6'd3:  u = mk(OP_MUL,  SRC_BETA,  SRC_S,    SRC_T,   1'b0);
            6'd4:  u = mk(OP_MUL,  SRC_T,     SRC_I,    SRC_INF, 1'b0);
            6'd5:  u = mk(OP_MUL,  SRC_ALPHA, SRC_E,    SRC_INC, 1'b0);
            6'd6:  u = mk(OP_MUL,  SRC_GAMMA, SRC_I,    SRC_CUR, 1'b0);
            6'd7:  u = mk(OP_MUL,  SRC_DELTA, SRC_I,    SRC_DTH, 1'b0);
            6'd8:  u = mk(OP_MUL,  SRC_EPS,   SRC_R,    SRC_WAN, 1'b0);
            6'd9:  u = mk(OP_MUL,  SRC_NU,    SRC_N,    SRC_T,   1'b0);
            6'd10: u = mk(OP_ADD,  SRC_T,     SRC_WAN,  SRC_PS,  1'b0);
            6'd11: u = mk(OP_MUL,  SRC_MU,    SRC_S,    SRC_T,   1'b0);
            6'd12: u = mk(OP_ADD,  SRC_INF,   SRC_T,    SRC_NS,  1'b0);
            6'd13: u = mk(OP_MUL,  SRC_MU,    SRC_E,    SRC_T,   1'b0);
            6'd14: u = mk(OP_ADD,  SRC_INC,   SRC_T,    SRC_NE,  1'b0);
            6'd15: u = mk(OP_ADD,  SRC_DTH,   SRC_CUR,  SRC_T,   1'b0);
            6'd16: u = mk(OP_MUL,  SRC_MU,    SRC_I,    SRC_U,   1'b0);
            6'd17: u = mk(OP_ADD,  SRC_T,     SRC_U,    SRC_NI,  1'b0);
            6'd18: u = mk(OP_MUL,  SRC_MU,    SRC_R,    SRC_T,   1'b0);
            6'd19: u = mk(OP_ADD,  SRC_T,     SRC_WAN,  SRC_NR,  1'b0);
            6'd20: u = mk(OP_DIFF, SRC_PS,    SRC_NS,   SRC_T,   1'b0);
            6'd21: u = mk(OP_MUL,  SRC_H,     SRC_T,    SRC_T,   1'b0);
            6'd22: u = mk(OP_UPD,  SRC_S,     SRC_T,    SRC_S,   1'b0);
            6'd23: u = mk(OP_DIFF, SRC_INF,   SRC_NE,   SRC_T,   1'b0);
            6'd24: u = mk(OP_MUL,  SRC_H,     SRC_T,    SRC_T,   1'b0);
            6'd25: u = mk(OP_UPD,  SRC_E,     SRC_T,    SRC_E,   1'b0);
            6'd26: u = mk(OP_DIFF, SRC_INC,   SRC_NI,   SRC_T,   1'b0);
            6'd27: u = mk(OP_MUL,  SRC_H,     SRC_T,    SRC_T,   1'b0);
            6'd28: u = mk(OP_UPD,  SRC_I,     SRC_T,    SRC_I,   1'b0);
            6'd29: u = mk(OP_DIFF, SRC_CUR,   SRC_NR,   SRC_T,   1'b0);
            6'd30: u = mk(OP_MUL,  SRC_H,     SRC_T,    SRC_T,   1'b0);
            6'd31: u = mk(OP_UPD,  SRC_R,     SRC_T,    SRC_R,   1'b0);
            6'd32: u = mk(OP_DIFF, SRC_DTH,   SRC_ZERO, SRC_T,   1'b0);
            6'd33: u = mk(OP_MUL,  SRC_H,     SRC_T,    SRC_T,   1'b0);
            6'd34: u = mk(OP_UPD,  SRC_D,     SRC_T,    SRC_D,   1'b0);
            6'd35: u = mk(OP_ADD,  SRC_S,     SRC_E,    SRC_TOT, 1'b0);
            6'd36: u = mk(OP_ADD,  SRC_TOT,   SRC_I,    SRC_TOT, 1'b0);
            6'd37: u = mk(OP_ADD,  SRC_TOT,   SRC_R,    SRC_TOT, 1'b1);
            default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_T,   1'b1);
        endcase
        return u;
    endfunction

endpackage

### design/seird_in_if.sv
// ----------------------------------------------------------------------------
// SEIRD input channel
// Valid/ready channel carrying a load or tick word.
// ----------------------------------------------------------------------------
interface seird_in_if;
    import seird_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [FIELD_W-1:0] init_susceptible;
    logic [FIELD_W-1:0] init_exposed;
    logic [FIELD_W-1:0] init_infected;

    modport source (
        output valid, kind, init_susceptible, init_exposed, init_infected,
        input  ready
    );

    modport sink (
        input  valid, kind, init_susceptible, init_exposed, init_infected,
        output ready
    );
endinterface

### design/seird_out_if.sv
// ----------------------------------------------------------------------------
// SEIRD result channel
// Valid/ready channel carrying the model state after each word.
// ----------------------------------------------------------------------------
interface seird_out_if;
    import seird_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] step_index;
    logic [FIELD_W-1:0] susceptible;
    logic [FIELD_W-1:0] exposed;
    logic [FIELD_W-1:0] infected;
    logic [FIELD_W-1:0] recovered;
    logic [FIELD_W-1:0] dead;
    logic [FIELD_W-1:0] alive_total;
    logic               saturated;

    modport source (
        output valid, step_index, susceptible, exposed, infected, recovered, dead,
               alive_total, saturated,
        input  ready
    );

    modport sink (
        input  valid, step_index, susceptible, exposed, infected, recovered, dead,
               alive_total, saturated,
        output ready
    );
endinterface

### design/seird_alu.sv
// ----------------------------------------------------------------------------
// SEIRD shared arithmetic unit
// Saturating add, absolute difference, clamped update and a digit-serial
// fixed-point multiply, one operation at a time.
// ----------------------------------------------------------------------------
module seird_alu #(
    parameter int VALUE_WIDTH = seird_pkg::DEF_VALUE_WIDTH,
    parameter int FRAC_BITS   = seird_pkg::DEF_FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  seird_pkg::alu_ctrl_t   ctrl,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output seird_pkg::alu_stat_t   stat,
    output logic [VALUE_WIDTH-1:0] res
);
    import seird_pkg::*;

    localparam int CHUNKS  = (VALUE_WIDTH + DIG_W - 1) / DIG_W;
    localparam int BPAD_W  = CHUNKS * DIG_W;
    localparam int PROD_W  = VALUE_WIDTH + BPAD_W;
    localparam int TOP_POS = FRAC_BITS + VALUE_WIDTH;
    localparam int EXT_W   = (PROD_W > TOP_POS) ? PROD_W : TOP_POS + 1;
    localparam int CNT_W   = $clog2(CHUNKS + 1);

    typedef enum logic {
        PH_IDLE,
        PH_MUL
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    logic                       clamp_reg, clamp_next;
    logic                       neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0]     a_reg, a_next;
    logic [BPAD_W-1:0]          b_reg, b_next;
    logic [PROD_W-1:0]          acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0]     res_reg, res_next;

    logic                       sub;
    logic [VALUE_WIDTH:0]       b_ext;
    logic [VALUE_WIDTH:0]       addend;
    logic [VALUE_WIDTH:0]       sum;
    logic [VALUE_WIDTH+DIG_W-1:0] part;
    logic [EXT_W-1:0]           ext;
    logic                       over;

    always_comb
    begin
        sub    = (ctrl.op == OP_DIFF) || ((ctrl.op == OP_UPD) && ctrl.neg);
        b_ext  = {1'b0, b};
        addend = sub ? (~b_ext + 1'b1) : b_ext;
        sum    = {1'b0, a} + addend;
        // Most significant digit first, so the accumulator only ever shifts left.
        part   = a_reg * b_reg[BPAD_W-1 -: DIG_W];
        ext    = EXT_W'(acc_reg);
        over   = |(ext >> TOP_POS);

        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        clamp_next = clamp_reg;
        neg_next   = neg_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (ctrl.start)
                begin
                    unique case (ctrl.op)
                        OP_MUL:
                        begin
                            a_next     = a;
                            b_next     = BPAD_W'(b);
                            acc_next   = '0;
                            cnt_next   = CNT_W'(CHUNKS);
                            phase_next = PH_MUL;
                        end
                        OP_DIFF:
                        begin
                            // A borrow means b is the larger; negate to get the magnitude.
                            res_next   = sum[VALUE_WIDTH] ? (~sum[VALUE_WIDTH-1:0] + 1'b1)
                                                          : sum[VALUE_WIDTH-1:0];
                            neg_next   = sum[VALUE_WIDTH];
                            clamp_next = 1'b0;
                            done_next  = 1'b1;
                        end
                        OP_ADD, OP_UPD:
                        begin
                            if (sub)
                            begin
                                res_next = sum[VALUE_WIDTH] ? '0 : sum[VALUE_WIDTH-1:0];
                            end
                            else
                            begin
                                res_next = sum[VALUE_WIDTH] ? '1 : sum[VALUE_WIDTH-1:0];
                            end
                            clamp_next = sum[VALUE_WIDTH];
                            neg_next   = 1'b0;
                            done_next  = 1'b1;
                        end
                    endcase
                end
            end
            PH_MUL:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next = (acc_reg << DIG_W) + PROD_W'(part);
                    b_next   = b_reg << DIG_W;
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    res_next   = over ? '1 : ext[FRAC_BITS +: VALUE_WIDTH];
                    clamp_next = over;
                    neg_next   = 1'b0;
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            clamp_reg <= 1'b0;
            neg_reg   <= 1'b0;
            a_reg     <= '0;
            b_reg     <= '0;
            acc_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            clamp_reg <= clamp_next;
            neg_reg   <= neg_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            acc_reg   <= acc_next;
            res_reg   <= res_next;
        end
    end

    assign stat.done  = done_reg;
    assign stat.clamp = clamp_reg;
    assign stat.neg   = neg_reg;
    assign res        = res_reg;

endmodule

### design/seird_euler_step_top.sv
// ----------------------------------------------------------------------------
// SEIRD forward-Euler step
// A load word runs only the alive-total tail of the micro-program; a tick word
// runs it all, mostly in 16 passes through the shared multiplier, which
// consumes one 16-bit digit a cycle. The next input word is taken in the
// cycle after the result is registered.
// Reset clears the rate registers, the five compartments and the step count.
// ----------------------------------------------------------------------------
module seird_euler_step_top #(
    parameter int VALUE_WIDTH = seird_pkg::DEF_VALUE_WIDTH,
    parameter int FRAC_BITS   = seird_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    seird_in_if.sink                          item,
    seird_out_if.source                       result,
    input  logic                              wr_en,
    input  logic [seird_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [seird_pkg::FIELD_W-1:0]     wr_data
);
    import seird_pkg::*;

    `include "seird_euler_step_top_macros.svh"

    typedef logic [VALUE_WIDTH-1:0] val_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t            state_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [FIELD_W-1:0] step_reg;
    logic              sat_reg;
    logic              neg_reg;

    val_t s_reg, e_reg, i_reg, r_reg, d_reg;
    val_t n_reg, inf_reg, inc_reg, cur_reg, dth_reg, wan_reg;
    val_t ps_reg, ns_reg, ne_reg, ni_reg, nr_reg;
    val_t t_reg, u_reg, tot_reg;
    val_t alpha_reg, beta_reg, gamma_reg, delta_reg, eps_reg, mu_reg, nu_reg, h_reg;

    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_step_reg;
    val_t               out_s_reg, out_e_reg, out_i_reg, out_r_reg, out_d_reg;
    val_t               out_tot_reg;
    logic               out_sat_reg;

    uop_t      uop;
    val_t      opnd_a, opnd_b, alu_res;
    alu_ctrl_t alu_ctrl;
    alu_stat_t alu_stat;
    logic      accept;
    logic      load_accept;
    logic      out_free;

    function automatic val_t pick(input src_t sel);
        val_t v;
        unique case (sel)
            SRC_S:     v = s_reg;
            SRC_E:     v = e_reg;
            SRC_I:     v = i_reg;
            SRC_R:     v = r_reg;
            SRC_D:     v = d_reg;
            SRC_N:     v = n_reg;
            SRC_INF:   v = inf_reg;
            SRC_INC:   v = inc_reg;
            SRC_CUR:   v = cur_reg;
            SRC_DTH:   v = dth_reg;
            SRC_WAN:   v = wan_reg;
            SRC_PS:    v = ps_reg;
            SRC_NS:    v = ns_reg;
            SRC_NE:    v = ne_reg;
            SRC_NI:    v = ni_reg;
            SRC_NR:    v = nr_reg;
            SRC_T:     v = t_reg;
            SRC_U:     v = u_reg;
            SRC_TOT:   v = tot_reg;
            SRC_ALPHA: v = alpha_reg;
            SRC_BETA:  v = beta_reg;
            SRC_GAMMA: v = gamma_reg;
            SRC_DELTA: v = delta_reg;
            SRC_EPS:   v = eps_reg;
            SRC_MU:    v = mu_reg;
            SRC_NU:    v = nu_reg;
            SRC_H:     v = h_reg;
            SRC_ZERO:  v = '0;
            default:   v = '0;
        endcase
        return v;
    endfunction

    assign uop         = prog_rom(pc_reg);
    assign accept      = item.valid && item.ready;
    assign load_accept = accept && (item.kind == KIND_LOAD);
    assign out_free    = !out_valid_reg || result.ready;

    always_comb
    begin
        opnd_a = pick(uop.a);
        opnd_b = pick(uop.b);
    end

    assign alu_ctrl.start = (state_reg == ST_ISSUE);
    assign alu_ctrl.op    = uop.op;
    assign alu_ctrl.neg   = neg_reg;

    seird_alu #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (alu_ctrl),
        .a     (opnd_a),
        .b     (opnd_b),
        .stat  (alu_stat),
        .res   (alu_res)
    );

    // Rate registers; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
            beta_reg  <= '0;
            gamma_reg <= '0;
            delta_reg <= '0;
            eps_reg   <= '0;
            mu_reg    <= '0;
            nu_reg    <= '0;
            h_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ALPHA: alpha_reg <= VALUE_WIDTH'(wr_data);
                REG_BETA:  beta_reg  <= VALUE_WIDTH'(wr_data);
                REG_GAMMA: gamma_reg <= VALUE_WIDTH'(wr_data);
                REG_DELTA: delta_reg <= VALUE_WIDTH'(wr_data);
                REG_EPS:   eps_reg   <= VALUE_WIDTH'(wr_data);
                REG_MU:    mu_reg    <= VALUE_WIDTH'(wr_data);
                REG_NU:    nu_reg    <= VALUE_WIDTH'(wr_data);
                REG_H:     h_reg     <= VALUE_WIDTH'(wr_data);
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            step_reg      <= '0;
            sat_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_step_reg  <= '0;
            out_s_reg     <= '0;
            out_e_reg     <= '0;
            out_i_reg     <= '0;
            out_r_reg     <= '0;
            out_d_reg     <= '0;
            out_tot_reg   <= '0;
            out_sat_reg   <= 1'b0;
            s_reg         <= '0;
            e_reg         <= '0;
            i_reg         <= '0;
            r_reg         <= '0;
            d_reg         <= '0;
            n_reg         <= '0;
            inf_reg       <= '0;
            inc_reg       <= '0;
            cur_reg       <= '0;
            dth_reg       <= '0;
            wan_reg       <= '0;
            ps_reg        <= '0;
            ns_reg        <= '0;
            ne_reg        <= '0;
            ni_reg        <= '0;
            nr_reg        <= '0;
            t_reg         <= '0;
            u_reg         <= '0;
            tot_reg       <= '0;
        end
        else
        begin
            // A new word may replace the one being taken in the same cycle.
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_step_reg  <= step_reg;
                out_s_reg     <= s_reg;
                out_e_reg     <= e_reg;
                out_i_reg     <= i_reg;
                out_r_reg     <= r_reg;
                out_d_reg     <= d_reg;
                out_tot_reg   <= tot_reg;
                out_sat_reg   <= sat_reg;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        sat_reg   <= 1'b0;
                        state_reg <= ST_ISSUE;
                        if (item.kind == KIND_LOAD)
                        begin
                            s_reg    <= VALUE_WIDTH'(item.init_susceptible);
                            e_reg    <= VALUE_WIDTH'(item.init_exposed);
                            i_reg    <= VALUE_WIDTH'(item.init_infected);
                            r_reg    <= '0;
                            d_reg    <= '0;
                            step_reg <= '0;
                            pc_reg   <= ALIVE_START;
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                            pc_reg   <= '0;
                        end
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (alu_stat.done)
                    begin
                        sat_reg <= sat_reg | alu_stat.clamp;
                        // The sign of a difference steers the update two steps later.
                        if (uop.op == OP_DIFF)
                        begin
                            neg_reg <= alu_stat.neg;
                        end
                        unique case (uop.dst)
                            SRC_S:   s_reg   <= alu_res;
                            SRC_E:   e_reg   <= alu_res;
                            SRC_I:   i_reg   <= alu_res;
                            SRC_R:   r_reg   <= alu_res;
                            SRC_D:   d_reg   <= alu_res;
                            SRC_N:   n_reg   <= alu_res;
                            SRC_INF: inf_reg <= alu_res;
                            SRC_INC: inc_reg <= alu_res;
                            SRC_CUR: cur_reg <= alu_res;
                            SRC_DTH: dth_reg <= alu_res;
                            SRC_WAN: wan_reg <= alu_res;
                            SRC_PS:  ps_reg  <= alu_res;
                            SRC_NS:  ns_reg  <= alu_res;
                            SRC_NE:  ne_reg  <= alu_res;
                            SRC_NI:  ni_reg  <= alu_res;
                            SRC_NR:  nr_reg  <= alu_res;
                            SRC_T:   t_reg   <= alu_res;
                            SRC_U:   u_reg   <= alu_res;
                            SRC_TOT: tot_reg <= alu_res;
                            default: ;
                        endcase
                        if (uop.last)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            pc_reg    <= pc_reg + 1'b1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign item.ready         = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.step_index  = out_step_reg;
    assign result.susceptible = FIELD_W'(out_s_reg);
    assign result.exposed     = FIELD_W'(out_e_reg);
    assign result.infected    = FIELD_W'(out_i_reg);
    assign result.recovered   = FIELD_W'(out_r_reg);
    assign result.dead        = FIELD_W'(out_d_reg);
    assign result.alive_total = FIELD_W'(out_tot_reg);
    assign result.saturated   = out_sat_reg;

    `SEIRD_ASSERT_SAME(a_alu_done_in_wait, alu_stat.done, state_reg == ST_WAIT, "stray ALU done")
    `SEIRD_ASSERT_NEXT(a_load_clears, load_accept, ~|{step_reg, r_reg, d_reg}, "load not cleared")
    `SEIRD_ASSERT_SAME(a_res_src, $rose(result.valid), $past(state_reg == ST_OUT), "stray result")

endmodule

### tb/tb_seird_euler_step_top.sv
// ----------------------------------------------------------------------------
// SEIRD Euler step testbench
// Drives load and tick words into the integrator under several rate settings
// and idle patterns. A predictor inside the bench works out each result word,
// and a checker compares every accepted word with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_seird_euler_step_top;
    import seird_pkg::*;

    localparam int          VW            = DEF_VALUE_WIDTH;
    localparam int          FB            = DEF_FRAC_BITS;
    localparam logic [63:0] VMAX          = (64'd1 << VW) - 64'd1;
    localparam logic [31:0] ONE_Q         = 32'd1 << FB;
    localparam int          NUM_RATE_REGS = int'(REG_H) + 1;
    localparam int          NUM_INDEXES   = 1 << CFG_INDEX_W;
    localparam int          DRAIN_CYCLES  = 160;
    localparam int          LIMIT_CYCLES  = 1_500_000;
    localparam int          REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [31:0] step_index;
        logic [31:0] susceptible;
        logic [31:0] exposed;
        logic [31:0] infected;
        logic [31:0] recovered;
        logic [31:0] dead;
        logic [31:0] alive_total;
        logic        saturated;
    } seird_word_t;

    typedef enum {RATES_ZERO, RATES_TYPICAL, RATES_WILD, RATES_MAX} rate_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [FIELD_W-1:0]     wr_data;

    seird_in_if  item_if ();
    seird_out_if result_if ();

    seird_euler_step_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_if),
        .result   (result_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Predictor state: the rates and the five compartments as the block holds them.
    // The rate table spans the whole index range; entries past the step size stay zero.
    logic [63:0] rate_q [NUM_INDEXES];
    logic [63:0] s_q, e_q, i_q, r_q, d_q;
    logic [31:0] steps_q;
    bit          clamp_hit;

    seird_word_t expected_q [$];

    int send_idle_pct = 10;
    int recv_idle_pct = 77;
    int err_count     = 0;
    int n_checked     = 0;
    int n_sat_seen    = 0;
    int n_loads       = 0;
    int n_ticks       = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb_seird_euler_step_top: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        p = p >> FB;
        if (p > VMAX)
        begin
            clamp_hit = 1'b1;
            return VMAX;
        end
        return p[63:0];
    endfunction

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t > {1'b0, VMAX})
        begin
            clamp_hit = 1'b1;
            return VMAX;
        end
        return t[63:0];
    endfunction

    // New value is y + h * (pos - neg), held within zero and the maximum.
    function automatic logic [63:0] euler_update(input logic [63:0] y, input logic [63:0] pos,
                                                 input logic [63:0] neg);
        logic [63:0] d;
        if (pos >= neg)
            return sat_sum(y, fx_mul(rate_q[REG_H], pos - neg));
        d = fx_mul(rate_q[REG_H], neg - pos);
        if (d > y)
        begin
            clamp_hit = 1'b1;
            return 64'd0;
        end
        return y - d;
    endfunction

    function automatic logic [63:0] alive_sum(input logic [63:0] s, input logic [63:0] e,
                                              input logic [63:0] i, input logic [63:0] r);
        return sat_sum(sat_sum(sat_sum(s, e), i), r);
    endfunction

    function automatic seird_word_t advance_model(input logic kind, input logic [31:0] ls,
                                                  input logic [31:0] le, input logic [31:0] li);
        logic [63:0] s, e, i, r, n;
        logic [63:0] inf, inc, cur, dth, wan;
        logic [63:0] ps, ns, ne, ni, nr;
        logic [63:0] tot;
        seird_word_t w;
        clamp_hit = 1'b0;
        if (kind == KIND_LOAD)
        begin
            s_q     = {32'd0, ls} & VMAX;
            e_q     = {32'd0, le} & VMAX;
            i_q     = {32'd0, li} & VMAX;
            r_q     = 64'd0;
            d_q     = 64'd0;
            steps_q = 32'd0;
        end
        else
        begin
            s   = s_q;
            e   = e_q;
            i   = i_q;
            r   = r_q;
            n   = alive_sum(s, e, i, r);
            inf = fx_mul(fx_mul(rate_q[REG_BETA], s), i);
            inc = fx_mul(rate_q[REG_ALPHA], e);
            cur = fx_mul(rate_q[REG_GAMMA], i);
            dth = fx_mul(rate_q[REG_DELTA], i);
            wan = fx_mul(rate_q[REG_EPS], r);
            ps  = sat_sum(fx_mul(rate_q[REG_NU], n), wan);
            ns  = sat_sum(inf, fx_mul(rate_q[REG_MU], s));
            ne  = sat_sum(inc, fx_mul(rate_q[REG_MU], e));
            ni  = sat_sum(sat_sum(dth, cur), fx_mul(rate_q[REG_MU], i));
            nr  = sat_sum(fx_mul(rate_q[REG_MU], r), wan);
            s_q = euler_update(s, ps, ns);
            e_q = euler_update(e, inf, ne);
            i_q = euler_update(i, inc, ni);
            r_q = euler_update(r, cur, nr);
            d_q = euler_update(d_q, dth, 64'd0);
            steps_q = steps_q + 32'd1;
        end
        tot           = alive_sum(s_q, e_q, i_q, r_q);
        w.step_index  = steps_q;
        w.susceptible = s_q[31:0];
        w.exposed     = e_q[31:0];
        w.infected    = i_q[31:0];
        w.recovered   = r_q[31:0];
        w.dead        = d_q[31:0];
        w.alive_total = tot[31:0];
        w.saturated   = clamp_hit;
        return w;
    endfunction

    function automatic logic [31:0] pick_rate(input rate_mode_t mode, input cfg_reg_t idx);
        case (mode)
            RATES_ZERO: return 32'd0;
            RATES_MAX:  return 32'hFFFF_FFFF;
            RATES_WILD:
            begin
                case ($urandom_range(3))
                    0:       return 32'd0;
                    1:       return 32'hFFFF_FFFF;
                    default: return $urandom;
                endcase
            end
            default:
            begin
                case (idx)
                    REG_ALPHA: return $urandom_range(ONE_Q / 2);
                    REG_BETA:  return $urandom_range(2 * ONE_Q);
                    REG_GAMMA: return $urandom_range(ONE_Q / 2);
                    REG_DELTA: return $urandom_range(ONE_Q / 8);
                    REG_EPS:   return $urandom_range(ONE_Q / 4);
                    REG_MU:    return $urandom_range(ONE_Q / 16);
                    REG_NU:    return $urandom_range(ONE_Q / 16);
                    default:   return $urandom_range(ONE_Q / 2, ONE_Q / 100);
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
                $display("mismatch in %s of result word %0d: expected %h, got %h",
                         name, n_checked, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        seird_word_t want;
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (expected_q.size() == 0)
            begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("result word arrived with nothing expected: step %h",
                             result_if.step_index);
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("step_index",  want.step_index,  result_if.step_index);
                check_field("susceptible", want.susceptible, result_if.susceptible);
                check_field("exposed",     want.exposed,     result_if.exposed);
                check_field("infected",    want.infected,    result_if.infected);
                check_field("recovered",   want.recovered,   result_if.recovered);
                check_field("dead",        want.dead,        result_if.dead);
                check_field("alive_total", want.alive_total, result_if.alive_total);
                check_field("saturated",   {31'd0, want.saturated},
                            {31'd0, result_if.saturated});
                if (want.saturated)
                    n_sat_seen++;
                n_checked++;
            end
        end
    end

    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers; each is entered and left at a falling edge.
    // ------------------------------------------------------------------------
    // Valid is left high on return so that a following word goes out without a gap.
    task automatic send_word(input logic kind, input logic [31:0] ls, input logic [31:0] le,
                             input logic [31:0] li);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid            <= 1'b1;
        item_if.kind             <= kind;
        item_if.init_susceptible <= ls;
        item_if.init_exposed     <= le;
        item_if.init_infected    <= li;
        @(posedge clk);
        while (item_if.ready !== 1'b1)
            @(posedge clk);
        expected_q.push_back(advance_model(kind, ls, le, li));
        if (kind == KIND_LOAD)
            n_loads++;
        else
            n_ticks++;
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_word(KIND_TICK, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_all_results();
        item_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_rate(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        if (idx < NUM_RATE_REGS)
            rate_q[idx] = {32'd0, val} & VMAX;
        @(negedge clk);
    endtask

    task automatic apply_rates(input rate_mode_t mode);
        wait_all_results();
        for (int k = 0; k < NUM_RATE_REGS; k++)
            write_rate(CFG_INDEX_W'(k), pick_rate(mode, cfg_reg_t'(k)));
        wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // All rates are still zero here, so the state must not move.
    task automatic test_tick_from_reset();
        send_tick();
        send_word(KIND_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick();
    endtask

    // Writes to indexes past the step size must leave every rate as it was.
    task automatic test_unknown_register();
        apply_rates(RATES_TYPICAL);
        for (int k = NUM_RATE_REGS; k < NUM_INDEXES; k++)
            write_rate(CFG_INDEX_W'(k), 32'hFFFF_FFFF);
        wr_en <= 1'b0;
        send_word(KIND_LOAD, ONE_Q - ONE_Q / 10, ONE_Q / 20, ONE_Q / 20);
        send_tick();
        send_tick();
    endtask

    task automatic test_typical_run();
        send_word(KIND_LOAD, ONE_Q - ONE_Q / 8, ONE_Q / 16, ONE_Q / 16);
        repeat (8) send_tick();
        send_word(KIND_LOAD, 32'd0, 32'd0, 32'd0);
        repeat (2) send_tick();
    endtask

    // Full-scale rates drive some compartments to the top and others to zero.
    task automatic test_extreme_rates();
        apply_rates(RATES_MAX);
        send_word(KIND_LOAD, ONE_Q, ONE_Q / 2, ONE_Q / 4);
        repeat (3) send_tick();
    endtask

    task automatic test_random_phase(input int s_pct, input int r_pct, input int n_items);
        int         sent;
        int         quota;
        int         pick;
        int         run_len;
        rate_mode_t mode;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        for (int blk = 0; blk < 3; blk++)
        begin
            if (blk == 1)
                mode = ($urandom_range(3) == 0) ? RATES_MAX : RATES_WILD;
            else
                mode = RATES_TYPICAL;
            apply_rates(mode);
            quota = (n_items * (blk + 1)) / 3;
            while (sent < quota)
            begin
                // Now and then hold off until the block has caught up completely.
                if ($urandom_range(9) == 0)
                    wait_all_results();
                pick = $urandom_range(9);
                if (pick < 7)
                begin
                    send_word(KIND_LOAD, $urandom_range(ONE_Q), $urandom_range(ONE_Q / 8),
                              $urandom_range(ONE_Q / 8));
                    sent++;
                end
                else if (pick == 7)
                begin
                    send_word(KIND_LOAD, $urandom, $urandom, $urandom);
                    sent++;
                end
                // Otherwise the run carries on from whatever state was left behind.
                run_len = $urandom_range(24, 1);
                repeat (run_len)
                begin
                    send_tick();
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        wr_en                    = 1'b0;
        wr_index                 = '0;
        wr_data                  = '0;
        item_if.valid            = 1'b0;
        item_if.kind             = KIND_LOAD;
        item_if.init_susceptible = '0;
        item_if.init_exposed     = '0;
        item_if.init_infected    = '0;
        for (int k = 0; k < NUM_INDEXES; k++)
            rate_q[k] = 64'd0;
        s_q     = 64'd0;
        e_q     = 64'd0;
        i_q     = 64'd0;
        r_q     = 64'd0;
        d_q     = 64'd0;
        steps_q = 32'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_tick_from_reset();
        test_unknown_register();
        test_typical_run();
        test_extreme_rates();
        test_random_phase(10, 77, 400);
        test_random_phase(77, 10, 350);
        test_random_phase(0, 0, 400);

        item_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_seird_euler_step_top: %0d loads and %0d Euler steps sent, %0d words checked",
                 n_loads, n_ticks, n_checked);
        $display("tb_seird_euler_step_top: %0d words saturated, %0d mismatches",
                 n_sat_seen, err_count);
        if (err_count == 0 && expected_q.size() == 0)
            $display("tb_seird_euler_step_top: done, clean");
        else
            $display("tb_seird_euler_step_top: done, errors");
        $finish;
    end

endmodule
